[sv/lzsd_pkg.sv]
// Shared types and constants for the LZSS stream decompressor.
// No dependencies; the controller, the datapath, the top level and the testbench import this package.
`default_nettype none

package lzsd_pkg;

  // History window geometry (fixed by the stream format)
  localparam int WIN_DEPTH = 4096;
  localparam int WIN_AW    = 12;

  // Write pointer value after reset
  localparam logic [WIN_AW-1:0] WR_PTR_RESET = WIN_AW'(1);

  // Token flags announced by one flag byte
  localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;

  typedef enum logic [2:0] {
    ST_FLAG,
    ST_TOKEN,
    ST_PAIR2,
    ST_COPY_RD,
    ST_COPY_EMIT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_flags;
    logic take_token;
    logic load_pair;
    logic start_copy;
    logic rd_en;
    logic emit_lit;
    logic emit_copy;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic lit;
    logic flags_one;
    logic flags_zero;
    logic done;
    logic out_free;
    logic copy_last;
  } dp_status_t;

endpackage

`default_nettype wire

[sv/lzsd_stream_if.sv]
// Valid/ready channel interfaces for compressed input and decompressed output.
// Depends on nothing; used by the top level of the decompressor.
`default_nettype none

interface lzsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_done;

  modport source (output valid, output out_byte, output last_of_run,
                  output stream_done, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input stream_done, output ready);
endinterface

`default_nettype wire

[sv/lzss_stream_decompressor.sv]
// Top level of the LZSS stream decompressor: controller plus datapath.
// Depends on lzsd_pkg, lzsd_stream_if, lzsd_ctrl and lzsd_datapath.
//
// Decompresses an LZSS stream with a 4096-byte history window, 12-bit window
// positions and 4-bit length codes. Compressed bytes arrive one per transfer on
// in_ch: a flag byte announces eight tokens, least significant bit first; a set
// bit is a literal byte, a clear bit a two-byte pair (length code in bits 7..4
// of the first byte, position bits 11..8 in bits 3..0, position bits 7..0 in
// the second byte) that copies length+MIN_EXTRA+1 bytes out of the window,
// overlapping copies included. Each decompressed byte leaves on out_ch with
// last_of_run set on the final byte caused by one input transfer, and
// stream_done set once the byte count reaches total_length. Program
// total_length through cfg_wr_en/cfg_wr_data only while the block is idle;
// once the count is reached, further input is taken and dropped, and a copy
// already under way always completes. Input is held off while a copy runs:
// every copied byte is read from the single-port window memory in ST_COPY_RD,
// then emitted and written back in ST_COPY_EMIT, so a byte just written is
// always visible to the next read. The window needs no clearing pass after
// reset: a fill count marks which entries were written, and unwritten
// entries read as zero. A single output register holds each byte until its
// transfer; a literal is taken only when that register is empty or transfers
// in the same cycle, and each copied byte likewise waits for it.
`default_nettype none

module lzss_stream_decompressor #(
  parameter int MIN_EXTRA = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  lzsd_in_if.sink     in_ch,
  lzsd_out_if.source  out_ch
);
  import lzsd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Parse tokens and sequence copies
  lzsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold window, counters and the output register
  lzsd_datapath #(
    .MIN_EXTRA (MIN_EXTRA)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_byte     (in_ch.in_byte),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .last_of_run (out_ch.last_of_run),
    .stream_done (out_ch.stream_done)
  );

endmodule

`default_nettype wire

[sv/lzsd_ctrl.sv]
// Token parser and copy sequencer state machine of the decompressor.
// Depends on lzsd_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module lzsd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lzsd_pkg::dp_status_t status,
  output lzsd_pkg::dp_cmd_t    cmd
);
  import lzsd_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        work;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FLAG;
    end else begin
      state <= state_next;
    end
  end

  // Input is taken unless a literal waits on a full output register or a copy runs
  always_comb begin
    case (state)
      ST_FLAG:  in_ready = 1'b1;
      ST_PAIR2: in_ready = 1'b1;
      ST_TOKEN: in_ready = !status.lit || status.out_free;
      default:  in_ready = 1'b0;
    endcase
  end

  assign work = in_valid && in_ready && !status.done;

  always_comb begin
    state_next = state;
    case (state)
      ST_FLAG: begin
        if (work) state_next = ST_TOKEN;
      end
      ST_TOKEN: begin
        if (work) begin
          if (status.lit) begin
            state_next = status.flags_one ? ST_FLAG : ST_TOKEN;
          end else begin
            state_next = ST_PAIR2;
          end
        end
      end
      ST_PAIR2: begin
        if (work) state_next = ST_COPY_RD;
      end
      ST_COPY_RD: begin
        state_next = ST_COPY_EMIT;
      end
      ST_COPY_EMIT: begin
        if (status.out_free) begin
          if (status.copy_last) begin
            state_next = status.flags_zero ? ST_FLAG : ST_TOKEN;
          end else begin
            state_next = ST_COPY_RD;
          end
        end
      end
      default: begin
        state_next = ST_FLAG;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_FLAG: begin
        cmd.load_flags = work;
      end
      ST_TOKEN: begin
        cmd.take_token = work;
        cmd.emit_lit   = work && status.lit;
        cmd.load_pair  = work && !status.lit;
      end
      ST_PAIR2: begin
        cmd.start_copy = work;
      end
      ST_COPY_RD: begin
        cmd.rd_en = 1'b1;
      end
      ST_COPY_EMIT: begin
        cmd.emit_copy = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/lzsd_datapath.sv]
// Window memory, token registers, counters and output register of the decompressor.
// Depends on lzsd_pkg; commanded by lzsd_ctrl.
`default_nettype none

module lzsd_datapath #(
  parameter int MIN_EXTRA = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [31:0]          cfg_wr_data,
  input  logic [7:0]           in_byte,
  input  lzsd_pkg::dp_cmd_t    cmd,
  output lzsd_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 last_of_run,
  output logic                 stream_done
);
  import lzsd_pkg::*;

  localparam int CNT_W = $clog2(MIN_EXTRA + 16);

  logic [7:0]        mem [WIN_DEPTH];
  logic [31:0]       total_length;
  logic [31:0]       produced_count;
  logic [31:0]       produced_next;
  logic [WIN_AW-1:0] wr_ptr;
  logic [WIN_AW:0]   fill;
  logic [7:0]        token_flags;
  logic [3:0]        flags_left;
  logic [7:0]        pair_first;
  logic [WIN_AW-1:0] src;
  logic [WIN_AW-1:0] src_rel;
  logic [CNT_W-1:0]  copy_left;
  logic [7:0]        rd_data;
  logic              rd_valid;
  logic              emit;
  logic [7:0]        emit_byte;

  assign emit          = cmd.emit_lit || cmd.emit_copy;
  // Entries not yet written since reset read as zero
  assign emit_byte     = cmd.emit_lit ? in_byte : (rd_valid ? rd_data : 8'h00);
  assign produced_next = (produced_count == 32'hFFFF_FFFF) ? produced_count
                                                           : produced_count + 32'd1;
  assign src_rel       = src - WR_PTR_RESET;

  assign status.lit        = token_flags[0];
  assign status.flags_one  = (flags_left == 4'd1);
  assign status.flags_zero = (flags_left == 4'd0);
  assign status.done       = (produced_count >= total_length);
  assign status.out_free   = !out_valid || out_ready;
  assign status.copy_last  = (copy_left == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      total_length   <= 32'd0;
      produced_count <= 32'd0;
      wr_ptr         <= WR_PTR_RESET;
      fill           <= '0;
      token_flags    <= 8'd0;
      flags_left     <= 4'd0;
      pair_first     <= 8'd0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) total_length <= cfg_wr_data;
      if (cmd.load_flags) begin
        token_flags <= in_byte;
        flags_left  <= FLAGS_PER_BYTE;
      end
      if (cmd.take_token) begin
        token_flags <= {1'b0, token_flags[7:1]};
        flags_left  <= flags_left - 4'd1;
      end
      if (cmd.load_pair) pair_first <= in_byte;
      if (emit) begin
        produced_count <= produced_next;
        wr_ptr         <= wr_ptr + WIN_AW'(1);
        if (fill != (WIN_AW+1)'(WIN_DEPTH)) fill <= fill + (WIN_AW+1)'(1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Copy source and remaining count
  always_ff @(posedge clk) begin
    if (cmd.start_copy) begin
      src       <= {pair_first[3:0], in_byte};
      copy_left <= CNT_W'(pair_first[7:4]) + CNT_W'(MIN_EXTRA);
    end else if (cmd.emit_copy) begin
      src       <= src + WIN_AW'(1);
      copy_left <= copy_left - CNT_W'(1);
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= emit_byte;
      last_of_run <= cmd.emit_lit || status.copy_last;
      stream_done <= (produced_next >= total_length);
    end
  end

  // Window memory: write on emit, registered read during copies
  always_ff @(posedge clk) begin
    if (emit) mem[wr_ptr] <= emit_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data  <= mem[src];
      rd_valid <= ({1'b0, src_rel} < fill);
    end
  end

endmodule

`default_nettype wire

[sv/lzsd_checker.sv]
// Port-level checks for the LZSS stream decompressor, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module lzsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run,
  input logic       stream_done
);

  // Reset drops any pending output
  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Hold a stalled result
  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped without transfer");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({out_byte, last_of_run, stream_done}))
    else $error("output payload changed while stalled");

  // A copy in progress keeps the input stalled
  a_copy_stalls_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |-> !in_ready)
    else $error("input taken in the middle of a copy");

endmodule

bind lzss_stream_decompressor lzsd_checker u_lzsd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .last_of_run (out_ch.last_of_run),
  .stream_done (out_ch.stream_done)
);

`default_nettype wire

[bench/lzss_stream_decompressor_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for lzss_stream_decompressor: directed token streams,
// then random streams with idling and back-pressure. Needs lzsd_pkg,
// lzsd_stream_if and the decompressor RTL; nothing else.

module lzss_stream_decompressor_test;
  import lzsd_pkg::*;

  localparam int MIN_EXTRA      = 1;
  localparam int IDLE_PCT       = 31;    // idle odds per cycle on either side
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES  = 16;    // covers flag / first pair byte work
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all

  // Hand-built opening stream. Flag 0xA3 reads LSB first as
  // literal, literal, pair, pair, pair, literal, pair, literal.
  localparam int DIRECTED_LEN = 22;
  localparam logic [7:0] DIRECTED_STREAM [DIRECTED_LEN] = '{
    8'hA3,
    8'h00,          // literal, lowest value
    8'hFF,          // literal, highest value
    8'hF0, 8'h02,   // longest copy from the byte just written: overlapping run
    8'h0F, 8'hFF,   // shortest copy from the top of the window (never written)
    8'hF0, 8'h00,   // longest copy from position zero (never written)
    8'hA5,          // literal
    8'h70, 8'h01,   // mid-length copy across the bytes written so far
    8'h5A,          // literal
    8'hFF,          // flag: eight literals
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } out_rec_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  lzsd_in_if  in_ch ();
  lzsd_out_if out_ch ();

  lzss_stream_decompressor #(
    .MIN_EXTRA (MIN_EXTRA)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Decoder shadow: window, token bookkeeping and the output count.
  logic [7:0]        win_mem [WIN_DEPTH];
  logic [WIN_AW-1:0] win_wptr;
  logic [7:0]        tok_flags;
  logic [3:0]        tok_left;
  ctrl_state_t       dec_state;
  logic [7:0]        pair_hi;
  logic [31:0]       out_count;
  logic [31:0]       out_limit;

  out_rec_t    pending_bytes [$];   // decompressed bytes still owed by the block
  logic [7:0]  pair_lo_plan;        // second pair byte picked with the first
  int unsigned mismatches = 0;
  int unsigned decoded_items = 0;   // transfers that the decoder did not drop
  int unsigned quiet_cycles = 0;
  bit          in_gaps;
  bit          out_gaps;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Write one byte to the window and queue it as an expected transfer.
  task automatic emit_byte(input logic [7:0] b, input logic last);
    out_rec_t r;
    win_mem[win_wptr] = b;
    win_wptr = win_wptr + WIN_AW'(1);
    // saturate the count at its top
    if (out_count != 32'hFFFF_FFFF) out_count = out_count + 32'd1;
    r.data = b;
    r.last = last;
    r.done = (out_count >= out_limit);
    pending_bytes.push_back(r);
  endtask

  // Advance the shadow decoder by one accepted compressed byte.
  task automatic decode_byte(input logic [7:0] b);
    logic              lit;
    logic [WIN_AW-1:0] rd_ptr;
    int                n;
    // length reached: the block takes the byte and drops it
    if (out_count >= out_limit) return;
    decoded_items++;
    case (dec_state)
      ST_TOKEN: begin
        lit = tok_flags[0];
        tok_flags = tok_flags >> 1;
        tok_left = tok_left - 4'd1;
        if (lit) begin
          dec_state = (tok_left == 4'd0) ? ST_FLAG : ST_TOKEN;
          emit_byte(b, 1'b1);
        end else begin
          pair_hi = b;
          dec_state = ST_PAIR2;
        end
      end
      ST_PAIR2: begin
        rd_ptr = {pair_hi[3:0], b};
        n = int'(pair_hi[7:4]) + MIN_EXTRA + 1;
        dec_state = (tok_left == 4'd0) ? ST_FLAG : ST_TOKEN;
        // read after each write, so overlapping copies repeat the pattern;
        // the copy runs in full even past the length
        for (int i = 0; i < n; i++) begin
          emit_byte(win_mem[rd_ptr], i == n - 1);
          rd_ptr = rd_ptr + WIN_AW'(1);
        end
      end
      default: begin
        tok_flags = b;
        tok_left = FLAGS_PER_BYTE;
        dec_state = ST_TOKEN;
      end
    endcase
  endtask

  // Offer one byte, wait for its transfer, then predict. Called at a rising edge.
  task automatic send_byte(input logic [7:0] b);
    while (in_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_byte(b);
  endtask

  // Drop valid, wait for every owed byte, then let the block go quiet.
  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_total_length(input logic [31:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    out_limit = v;
  endtask

  // Pick the byte that keeps the stream well formed for the decoder's current
  // state, with one byte in ten pure noise. Most copies reach a short way back
  // so that they overlap recent output.
  function automatic logic [7:0] next_stream_byte();
    logic [WIN_AW-1:0] pos;
    if ($urandom_range(99) < 10) return 8'($urandom);
    case (dec_state)
      ST_TOKEN: begin
        if (tok_flags[0]) return 8'($urandom);
        if ($urandom_range(99) < 70) pos = win_wptr - WIN_AW'($urandom_range(1, 24));
        else pos = WIN_AW'($urandom);
        pair_lo_plan = pos[7:0];
        return {4'($urandom), pos[11:8]};
      end
      ST_PAIR2: return pair_lo_plan;
      default:  return 8'($urandom);
    endcase
  endfunction

  // Random stream under a fresh length, optionally with a receiver hold-off.
  task automatic run_random_segment(input int unsigned n_items,
                                    input logic [31:0] limit, input bit hold);
    int unsigned stop_at;
    drain_and_settle();
    set_total_length(limit);
    if (hold) hold_req = 1'b1;
    stop_at = decoded_items + n_items;
    while (decoded_items < stop_at && out_count < out_limit)
      send_byte(next_stream_byte());
    // once the length is reached, keep offering bytes: they must be dropped
    if (out_count >= out_limit) repeat (3) send_byte(8'($urandom));
  endtask

  // ---------------------------------------------------------------- tests

  // Length zero: every byte is taken and dropped.
  task automatic test_zero_length();
    drain_and_settle();
    set_total_length(32'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // Literal extremes, longest and shortest copies, overlap, untouched window.
  task automatic test_directed_tokens();
    drain_and_settle();
    set_total_length(out_count + 32'd200);
    foreach (DIRECTED_STREAM[i]) send_byte(DIRECTED_STREAM[i]);
  endtask

  // Length reached in the middle of a copy: the copy finishes, then input drops.
  task automatic test_length_cut();
    logic [WIN_AW-1:0] pos;
    drain_and_settle();
    set_total_length(out_count + 32'd5);
    pos = win_wptr - WIN_AW'(3);
    send_byte(8'h00);                  // flag: all pairs
    send_byte({4'hF, pos[11:8]});
    send_byte(pos[7:0]);
    send_byte(8'hFF);
    send_byte(8'h3C);
  endtask

  task automatic test_random_idle();
    run_random_segment(120, out_count + 32'd400, 1'b0);
  endtask

  // Long stretch with no idling on either side.
  task automatic test_no_idle();
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    run_random_segment(100, out_count + 32'd350, 1'b0);
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering, so the block backs up.
  task automatic test_backpressure();
    in_gaps = 1'b0;
    run_random_segment(60, out_count + 32'd200, 1'b1);
    in_gaps = 1'b1;
  endtask

  // Largest length: stream_done never rises.
  task automatic test_full_length();
    run_random_segment(200, 32'hFFFF_FFFF, 1'b0);
  endtask

  // --------------------------------------------------------------- sequence

  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    in_gaps       = 1'b1;
    out_gaps      = 1'b1;
    hold_req      = 1'b0;
    pair_lo_plan  = '0;
    // shadow decoder in its reset state
    foreach (win_mem[i]) win_mem[i] = '0;
    win_wptr  = WR_PTR_RESET;
    tok_flags = '0;
    tok_left  = '0;
    dec_state = ST_FLAG;
    pair_hi   = '0;
    out_count = '0;
    out_limit = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_zero_length();
    test_directed_tokens();
    test_length_cut();
    test_random_idle();
    test_no_idle();
    test_backpressure();
    test_full_length();

    drain_and_settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: random stalls, plus the long hold-off when one is requested.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(out_gaps && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Compare each output transfer against the oldest owed byte.
  always @(posedge clk) begin
    out_rec_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        report("byte with none owed", 32'(out_ch.out_byte), 32'd0);
      end else begin
        want = pending_bytes.pop_front();
        if (out_ch.out_byte !== want.data)
          report("out_byte", 32'(out_ch.out_byte), 32'(want.data));
        if (out_ch.last_of_run !== want.last)
          report("last_of_run", 32'(out_ch.last_of_run), 32'(want.last));
        if (out_ch.stream_done !== want.done)
          report("stream_done", 32'(out_ch.stream_done), 32'(want.done));
      end
    end
  end

  // Watchdog: give up when neither side moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles, %0d bytes owed",
               $time, WATCHDOG_LIMIT, pending_bytes.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[sim.f]
sv/lzsd_pkg.sv
sv/lzsd_stream_if.sv
sv/lzsd_ctrl.sv
sv/lzsd_datapath.sv
sv/lzss_stream_decompressor.sv
sv/lzsd_checker.sv
bench/lzss_stream_decompressor_test.sv
